/* hdl/lzss_pkg.sv */
// Shared types and constants for the LZSS stream decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lzss_pkg;

  localparam int WINDOW_BYTES = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_BYTES);
  localparam int CNT_W        = 24;
  localparam int LEN_W        = 5;
  localparam int LEN_BIAS     = 3;
  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);

  localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(12'hFEE);
  localparam logic [CNT_W-1:0]  LIMIT_RESET = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_MATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        value;
    logic [WIN_AW-1:0] offset;
    logic [3:0]        len_code;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             run_last;
    logic [CNT_W-1:0] produced_count;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/lzss_front.sv */
// Token parser: takes compressed bytes and turns them into copy commands.
// Depends on lzss_pkg.
`default_nettype none

module lzss_front
  import lzss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire in_item_t in_item,
  output logic          full,
  input  wire logic     q_full,
  input  wire logic     back_clearing,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [8:0] flag_shift;
  logic [8:0] flag_shift_next;
  logic       match_phase;
  logic       match_phase_next;
  logic [7:0] offset_low;
  logic       accept;

  assign full   = q_full || back_clearing;
  assign accept = push && !full;

  always_comb begin
    flag_shift_next  = flag_shift;
    match_phase_next = match_phase;
    q_cmd.kind       = CMD_NONE;
    q_cmd.value      = in_item.in_byte;
    q_cmd.offset     = {in_item.in_byte[7:4], offset_low};
    q_cmd.len_code   = in_item.in_byte[3:0];
    q_cmd.last       = in_item.stream_last;
    if (flag_shift[8:1] == 8'd0) begin
      // load a new flag byte above a marker bit
      flag_shift_next  = {1'b1, in_item.in_byte};
      match_phase_next = 1'b0;
    end else if (flag_shift[0]) begin
      q_cmd.kind       = CMD_LIT;
      flag_shift_next  = {1'b0, flag_shift[8:1]};
      match_phase_next = 1'b0;
    end else if (!match_phase) begin
      match_phase_next = 1'b1;
    end else begin
      q_cmd.kind       = CMD_MATCH;
      flag_shift_next  = {1'b0, flag_shift[8:1]};
      match_phase_next = 1'b0;
    end
    q_push = accept && ((q_cmd.kind != CMD_NONE) || in_item.stream_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_shift  <= 9'd0;
      match_phase <= 1'b0;
      offset_low  <= 8'd0;
    end else if (accept) begin
      if (in_item.stream_last) begin
        // drop any unfinished token at stream end
        flag_shift  <= 9'd0;
        match_phase <= 1'b0;
        offset_low  <= 8'd0;
      end else begin
        flag_shift  <= flag_shift_next;
        match_phase <= match_phase_next;
        if (flag_shift[8:1] != 8'd0 && !flag_shift[0] && !match_phase) begin
          offset_low <= in_item.in_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lzss_cmd_fifo.sv */
// Short command queue between the token parser and the copy engine.
// Depends on lzss_pkg.
`default_nettype none

module lzss_cmd_fifo
  import lzss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  output logic      q_full,
  input  wire logic rd_en,
  output cmd_t      rd_cmd,
  output logic      q_empty
);

  cmd_t                 entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr;
  logic [CMDQ_AW-1:0]   rd_ptr;
  logic [CMDQ_AW:0]     fill;
  logic                 do_wr;
  logic                 do_rd;

  assign q_full  = (fill == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign q_empty = (fill == '0);
  assign rd_cmd  = entries[rd_ptr];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lzss_back.sv */
// Copy engine: history window, output limit, result register, clearing pass.
// Depends on lzss_pkg.
`default_nettype none

module lzss_back
  import lzss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] output_limit,
  input  wire cmd_t             q_cmd,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  empty,
  input  wire logic             pop,
  output out_item_t             out_item
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LIT,
    S_MRD,
    S_MWR
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [7:0]        window [WINDOW_BYTES];
  logic [7:0]        rd_data;
  logic [WIN_AW-1:0] clr_addr;
  logic [WIN_AW-1:0] wp;
  logic [WIN_AW-1:0] src;
  logic [LEN_W-1:0]  remain;
  logic [CNT_W-1:0]  count;
  logic              out_valid;

  logic              out_free;
  logic              limit_hit;
  logic [CNT_W-1:0]  count_inc;
  logic              hit_after;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic              step_done;
  logic              restart;
  logic              mem_we;
  logic [WIN_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign clearing  = (state == S_CLEAR);
  assign empty     = !out_valid;
  assign out_free  = !out_valid || pop;
  assign limit_hit = (count >= output_limit);
  assign count_inc = count + 1'b1;
  assign hit_after = (count_inc >= output_limit);
  assign q_pop     = (state == S_IDLE) && !q_empty;

  always_comb begin
    emit      = out_free && !limit_hit && ((state == S_LIT) || (state == S_MWR));
    emit_byte = (state == S_LIT) ? cmd.value : rd_data;
    emit_last = (state == S_LIT) || (remain == LEN_W'(1)) || hit_after;
    // command finished this cycle
    step_done = ((state == S_LIT) && (limit_hit || out_free)) ||
                ((state == S_MWR) && (limit_hit || (out_free && emit_last)));
    // stream ends: rewind pointer and count, start the clearing pass
    restart   = (step_done && cmd.last) ||
                ((state == S_IDLE) && !q_empty && q_cmd.last &&
                 (q_cmd.kind != CMD_LIT) && (q_cmd.kind != CMD_MATCH));
    mem_we    = clearing || emit;
    mem_waddr = clearing ? clr_addr : wp;
    mem_wdata = clearing ? 8'd0 : emit_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window[mem_waddr] <= mem_wdata;
    end
    if (state == S_MRD) begin
      rd_data <= window[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      wp        <= WP_START;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid               <= 1'b1;
        out_item.out_byte       <= emit_byte;
        out_item.run_last       <= emit_last;
        out_item.produced_count <= count_inc;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        wp    <= WP_START;
        count <= '0;
      end else if (emit) begin
        wp    <= wp + 1'b1;
        count <= count_inc;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {WIN_AW{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd    <= q_cmd;
            src    <= q_cmd.offset;
            remain <= LEN_W'(q_cmd.len_code) + LEN_W'(LEN_BIAS);
            unique case (q_cmd.kind)
              CMD_LIT:   state <= S_LIT;
              CMD_MATCH: state <= S_MRD;
              default: begin
                if (q_cmd.last) begin
                  state    <= S_CLEAR;
                  clr_addr <= '0;
                end
              end
            endcase
          end
        end
        S_LIT: begin
          if (step_done) begin
            if (cmd.last) begin
              state    <= S_CLEAR;
              clr_addr <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          if (step_done) begin
            if (cmd.last) begin
              state    <= S_CLEAR;
              clr_addr <= '0;
            end else begin
              state <= S_IDLE;
            end
          end else if (out_free) begin
            src    <= src + 1'b1;
            remain <= remain - 1'b1;
            state  <= S_MRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/lzss_stream_decoder.sv */
// Top level of the LZSS stream decoder: parser, command queue, copy engine.
// Depends on lzss_pkg, lzss_front, lzss_cmd_fifo and lzss_back.
`default_nettype none

// LZSS decoder with a 4096-byte history window (12-bit offset, 4-bit length,
// flag bits taken LSB first, window write pointer starting at 0xFEE). Push one
// compressed byte per transaction; pop decoded bytes, each tagged with the
// running byte count of the stream and a run_last bit on the final byte a
// given input byte caused. Flag bytes and the first byte of a match produce
// nothing. Bytes past output_limit are dropped and not written to the window.
// After the byte marked stream_last, parser state resets at once and the copy
// engine zeroes the whole window, during which full is high. The same clearing
// pass runs after reset. The parser takes one byte per cycle, unless the queue
// is full or the window is clearing, into a four-entry command queue; the copy
// engine then writes a literal straight out and copies a match (3 to 18 bytes)
// as a read-then-write pair per byte on the single window memory. Write
// output_limit only while the block is idle.

module lzss_stream_decoder
  import lzss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire in_item_t         in_item,
  output logic                  empty,
  input  wire logic             pop,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] output_limit;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic             back_clearing;
  cmd_t             push_cmd;
  cmd_t             head_cmd;

  // Hold the limit across streams; reset opens it fully.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      output_limit <= cfg_data;
    end
  end

  // Parse tokens; stall while the queue is full or the window is clearing.
  lzss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .in_item       (in_item),
    .full          (full),
    .q_full        (q_full),
    .back_clearing (back_clearing),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  lzss_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_cmd  (push_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (head_cmd),
    .q_empty (q_empty)
  );

  // Carry out literals and matches against the window; advance the count.
  lzss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .output_limit (output_limit),
    .q_cmd        (head_cmd),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .clearing     (back_clearing),
    .empty        (empty),
    .pop          (pop),
    .out_item     (out_item)
  );

endmodule

`default_nettype wire

/* bench/lzss_decode_checker.sv */
`timescale 1ns / 100ps
// Checker for lzss_stream_decoder: watches both queue ports and the config port,
// predicts every decoded byte and compares it with what the block hands out.
// Depends on lzss_pkg for the item types and window constants.

module lzss_decode_checker
  import lzss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             full,
  input  wire in_item_t         in_item,
  input  wire logic             empty,
  input  wire logic             pop,
  input  wire out_item_t        out_item,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [7:0]        hist [WINDOW_BYTES];
  logic [WIN_AW-1:0] wr_ptr;
  logic [8:0]        flag_bits;
  logic              in_match;
  logic [7:0]        match_lo;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  limit;
  out_item_t         burst[$];
  out_item_t         expected_bytes[$];
  int                errs = 0;

  task automatic clear_stream();
    for (int i = 0; i < WINDOW_BYTES; i++) hist[i] = 8'h00;
    wr_ptr     = WP_START;
    flag_bits  = '0;
    in_match   = 1'b0;
    match_lo   = '0;
    byte_count = '0;
  endtask

  // Drop the byte once the limit is reached: no output, no window write.
  task automatic store_byte(input logic [7:0] b);
    out_item_t r;
    if (byte_count < limit && burst.size() < 18) begin
      hist[wr_ptr] = b;
      wr_ptr       = wr_ptr + 1'b1;
      byte_count   = byte_count + 1'b1;
      r.out_byte       = b;
      r.run_last       = 1'b0;
      r.produced_count = byte_count;
      burst.push_back(r);
    end
  endtask

  task automatic decode_byte(input in_item_t it);
    logic [WIN_AW-1:0] src;
    int                n;
    out_item_t         tail;
    burst.delete();
    if (flag_bits <= 9'd1) begin
      flag_bits = {1'b1, it.in_byte};
      in_match  = 1'b0;
    end else if (flag_bits[0]) begin
      store_byte(it.in_byte);
      flag_bits = flag_bits >> 1;
      in_match  = 1'b0;
    end else if (!in_match) begin
      match_lo = it.in_byte;
      in_match = 1'b1;
    end else begin
      src = {it.in_byte[7:4], match_lo};
      n   = it.in_byte[3:0] + LEN_BIAS;
      // read before write, byte by byte, so overlapping copies repeat data
      for (int i = 0; i < n; i++) begin
        store_byte(hist[src]);
        src = src + 1'b1;
      end
      flag_bits = flag_bits >> 1;
      in_match  = 1'b0;
    end
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.run_last = 1'b1;
      burst.push_back(tail);
    end
    while (burst.size() > 0) expected_bytes.push_back(burst.pop_front());
    if (it.stream_last) clear_stream();
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected output byte %0h, produced_count %0d", got.out_byte,
             got.produced_count);
      errs++;
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errs++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
        errs++;
      end
      if (got.produced_count !== want.produced_count) begin
        $error("produced_count: expected %0d, actual %0d", want.produced_count,
               got.produced_count);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_stream();
      limit = LIMIT_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_we) limit = cfg_data;
      if (push && !full) decode_byte(in_item);
      if (pop && !empty) check_result(out_item);
    end
    fail_count <= errs;
    pending    <= expected_bytes.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the lzss_stream_decoder bench: clock, reset, stimulus and verdict.
// Depends on lzss_pkg, the decoder RTL and lzss_decode_checker.

module tb_top;
  import lzss_pkg::*;

  // Longest stretch with no transaction on either queue port. The slowest
  // legitimate quiet spell is the window clear plus a drain pause.
  localparam int WATCHDOG_CYCLES = 20000;
  // Settle time after the last expected byte: covers commands past the limit
  // still queued (four entries plus the one in the copy engine).
  localparam int DRAIN_CYCLES    = 200;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             push     = 1'b0;
  in_item_t         in_item  = '0;
  logic             pop      = 1'b0;
  logic             cfg_we   = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             full;
  logic             empty;
  out_item_t        out_item;
  int               fail_count;
  int               pending;

  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  int               quiet         = 0;
  int               sent          = 0;
  int               stream_left   = 20;
  logic [WIN_AW-1:0] wp_guess     = WP_START;
  logic             just_ended    = 1'b0;

  always #2 clk = ~clk;

  lzss_stream_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  lzss_decode_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: pop decided fresh each cycle; with stall_pct at zero it always
  // pops, so results drain at full rate.
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_CYCLES) begin
      $display("** lzss_stream_decoder: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one compressed byte and hold it until the transaction completes.
  // Idle gaps come first, so push drops only in cycles with no new item and
  // stays high straight through back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= {b, lst};
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
  endtask

  // Send a byte of the running random stream; mark stream_last when the
  // stream's planned length runs out, then plan the next stream.
  task automatic put_stream(input logic [7:0] b);
    just_ended = (stream_left <= 1);
    send_byte(b, just_ended);
    sent++;
    if (just_ended) begin
      stream_left = $urandom_range(6, 40);
      wp_guess    = WP_START;
    end else begin
      stream_left--;
    end
  endtask

  // Stop pushing and wait for every expected byte, then let the block settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write output_limit only with the block idle: drained and past any
  // window clear (full is held high for the whole clearing pass).
  task automatic set_limit(input logic [CNT_W-1:0] v);
    drain();
    while (full !== 1'b0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly well-formed token groups with random content; matches usually
  // point just behind the write pointer so they copy fresh, often
  // overlapping data. About one pick in ten is a lone byte of plain noise.
  task automatic random_traffic(input int n);
    int                target;
    logic [7:0]        flag;
    logic [WIN_AW-1:0] off;
    logic [3:0]        len_code;
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(99) < 10) begin
        put_stream(8'($urandom_range(255)));
      end else begin
        flag = 8'($urandom_range(255));
        put_stream(flag);
        for (int k = 0; k < 8 && sent < target && !just_ended; k++) begin
          if (flag[k]) begin
            put_stream(8'($urandom_range(255)));
            if (!just_ended) wp_guess = wp_guess + 1'b1;
          end else begin
            len_code = 4'($urandom_range(15));
            if ($urandom_range(99) < 70)
              off = wp_guess - WIN_AW'($urandom_range(1, 24));
            else
              off = WIN_AW'($urandom_range(WINDOW_BYTES - 1));
            put_stream(off[7:0]);
            if (sent < target && !just_ended) begin
              put_stream({off[11:8], len_code});
              if (!just_ended)
                wp_guess = wp_guess + WIN_AW'(len_code) + WIN_AW'(LEN_BIAS);
            end
          end
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed stream at the reset limit. Flag 0xA3, LSB first:
    // literal, literal, match, match, match, literal, match, literal.
    send_byte(8'hA3, 1'b0);
    send_byte(8'h00, 1'b0);   // literal, lowest value
    send_byte(8'hFF, 1'b0);   // literal, highest value
    send_byte(8'hEE, 1'b0);   // match at 0xFEE, len 3: overlaps the write pointer
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);   // match at 0x000, len 18: longest copy
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);   // match at 0xFFF, len 8: source wraps the window
    send_byte(8'hF5, 1'b0);
    send_byte(8'h5A, 1'b0);   // literal
    send_byte(8'hF0, 1'b0);   // match at 0xFF0, len 18
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);   // literal
    send_byte(8'h00, 1'b0);   // new flag: all matches
    send_byte(8'h34, 1'b1);   // first match byte, stream ends: match dropped
    // Stream made of a flag byte alone: unused token bits dropped at the end.
    send_byte(8'hC3, 1'b1);
    // Stream ending on a literal.
    send_byte(8'h01, 1'b0);
    send_byte(8'h7E, 1'b1);

    // Limit reached inside a match; the trailing literal is dropped too.
    set_limit(24'd2);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'hF1, 1'b0);
    send_byte(8'h77, 1'b1);

    // No idling, unlimited output.
    set_limit(LIMIT_RESET);
    random_traffic(20);

    // Sender idle most cycles; zero limit: every byte dropped.
    send_idle_pct = 65;
    set_limit('0);
    random_traffic(15);

    // Receiver stalls most cycles; small limit, cut mid-stream. Halfway,
    // hold the sender until every expected byte has drained.
    send_idle_pct = 0;
    stall_pct     = 65;
    set_limit(CNT_W'($urandom_range(5, 60)));
    random_traffic(15);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    random_traffic(15);

    // Both sides idling.
    send_idle_pct = 26;
    stall_pct     = 26;
    set_limit(24'd1);
    random_traffic(15);
    set_limit(LIMIT_RESET);
    random_traffic(10);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("** lzss_stream_decoder: PASSED **");
    end else begin
      $display("** lzss_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule

/* lzss_stream_decoder.f */
hdl/lzss_pkg.sv
hdl/lzss_front.sv
hdl/lzss_cmd_fifo.sv
hdl/lzss_back.sv
hdl/lzss_stream_decoder.sv
bench/lzss_decode_checker.sv
bench/tb_top.sv
